### design/sfdl_pkg.sv
// Shared types, constants and helper functions for the stereo flanger delay line.
// No dependencies; compiled before every module of the block.
package sfdl_pkg;

    // Default sizes handed to the top level parameters
    localparam int DELAY_FRAMES_DEF = 65536;
    localparam int CHANNELS_DEF     = 2;
    localparam int SINE_ENTRIES_DEF = 1024;

    // Configuration port
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_BASE_DELAY = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEPTH      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_INC  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DRY        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WET        = 3'd5;

    // Register reset values
    localparam logic [23:0]        BASE_DELAY_RST = 24'd12288;
    localparam logic [23:0]        DEPTH_RST      = 24'd12288;
    localparam logic [31:0]        PHASE_INC_RST  = 32'd44739;
    localparam logic signed [16:0] GAIN_RST       = 17'sd16384;
    localparam logic [31:0]        LFO_PHASE_RST  = 32'h4000_0000;

    // Sine polynomial coefficients, Q30
    localparam longint POLY_C1 = 64'sd1686629713;
    localparam longint POLY_C3 = -64'sd693598668;
    localparam longint POLY_C5 = 64'sd85569306;
    localparam longint POLY_C7 = -64'sd5026993;
    localparam longint POLY_C9 = 64'sd172271;

    typedef struct packed {
        logic signed [15:0] in_left;
        logic signed [15:0] in_right;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] out_left;
        logic signed [15:0] out_right;
    } out_word_t;

    typedef struct packed {
        logic [23:0]        base_delay_frames;
        logic [23:0]        depth_frames;
        logic [31:0]        phase_increment;
        logic signed [16:0] feedback_gain;
        logic signed [16:0] dry_gain;
        logic signed [16:0] wet_gain;
    } cfg_t;

    // Controller states, one-hot
    typedef enum logic [13:0] {
        ST_CLEAR  = 14'b00000000000001,
        ST_IDLE   = 14'b00000000000010,
        ST_ROM_A  = 14'b00000000000100,
        ST_ROM_B  = 14'b00000000001000,
        ST_LFO    = 14'b00000000010000,
        ST_DELAY  = 14'b00000000100000,
        ST_ADDR   = 14'b00000001000000,
        ST_WR_IN  = 14'b00000010000000,
        ST_RD1    = 14'b00000100000000,
        ST_RD2    = 14'b00001000000000,
        ST_INTERP = 14'b00010000000000,
        ST_STORE  = 14'b00100000000000,
        ST_MIX    = 14'b01000000000000,
        ST_FINISH = 14'b10000000000000
    } state_t;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_ROM_A,
        OP_ROM_B,
        OP_LFO,
        OP_DELAY,
        OP_ADDR,
        OP_WR_IN,
        OP_RD1,
        OP_RD2,
        OP_INTERP,
        OP_STORE,
        OP_MIX,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic last_chan;
        logic out_busy;
    } status_t;

    // Clamp a wide signed value to 16 bits
    function automatic logic signed [15:0] sat16(logic signed [35:0] v);
        logic signed [15:0] r;
        if (v > 36'sd32767)
            r = 16'sh7FFF;
        else if (v < -36'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    // Sine of a 32-bit phase in Q1.15, evaluated at elaboration for the table
    function automatic logic signed [15:0] sine_of_phase(longint u);
        longint q;
        longint f;
        longint x;
        longint x2;
        longint p;
        longint s;
        q  = (u >>> 30) & 64'sd3;
        f  = u & 64'sh3FFF_FFFF;
        x  = ((q & 64'sd1) != 0) ? ((64'sd1 <<< 30) - f) : f;
        x2 = (x * x) >>> 30;
        p  = POLY_C9;
        p  = POLY_C7 + ((p * x2) >>> 30);
        p  = POLY_C5 + ((p * x2) >>> 30);
        p  = POLY_C3 + ((p * x2) >>> 30);
        p  = POLY_C1 + ((p * x2) >>> 30);
        s  = (((p * x) >>> 30) + 64'sd16384) >>> 15;
        if (s < 0)
            s = 0;
        if (s > 32767)
            s = 32767;
        if (q >= 2)
            s = -s;
        return s[15:0];
    endfunction

endpackage

### design/stereo_flanger_delay_line_top.sv
// Top level of the stereo flanger delay line: configuration registers,
// controller and datapath. Depends on sfdl_pkg, sfdl_ctrl and sfdl_datapath.
//
// Stereo flanger: each input word is one Q1.15 frame; each output word is the
// flanged frame, saturated. A sine LFO sweeps an interpolated delay with
// feedback and a dry/wet mix. After reset the delay store is cleared, one entry
// per cycle, during which no input word is taken; configuration writes are
// accepted throughout. A frame then runs through the sine table reads, LFO,
// delay and address steps, the steps of each channel and the finish step to
// its output word, and no new frame is accepted until finish is through: the
// store has a single port, so each channel's input write, two delayed reads,
// interpolation, feedback write and mix go one after another, and the two sine
// table reads of the LFO share one read port. The next frame is accepted while
// an output word waits to be taken.
module stereo_flanger_delay_line_top #(
    parameter int DELAY_FRAMES = sfdl_pkg::DELAY_FRAMES_DEF,
    parameter int CHANNELS     = sfdl_pkg::CHANNELS_DEF,
    parameter int SINE_ENTRIES = sfdl_pkg::SINE_ENTRIES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                src_valid,
    output logic                                src_ready,
    input  sfdl_pkg::in_word_t                  src_word,
    output logic                                dst_valid,
    input  logic                                dst_ready,
    output sfdl_pkg::out_word_t                 dst_word,
    input  logic                                cfg_we,
    input  logic [sfdl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sfdl_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sfdl_pkg::*;

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t status;
    state_t  state;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_delay_frames <= BASE_DELAY_RST;
            cfg_reg.depth_frames      <= DEPTH_RST;
            cfg_reg.phase_increment   <= PHASE_INC_RST;
            cfg_reg.feedback_gain     <= GAIN_RST;
            cfg_reg.dry_gain          <= GAIN_RST;
            cfg_reg.wet_gain          <= GAIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASE_DELAY: cfg_reg.base_delay_frames <= cfg_data[23:0];
                REG_DEPTH:      cfg_reg.depth_frames      <= cfg_data[23:0];
                REG_PHASE_INC:  cfg_reg.phase_increment   <= cfg_data;
                REG_FEEDBACK:   cfg_reg.feedback_gain     <= signed'(cfg_data[16:0]);
                REG_DRY:        cfg_reg.dry_gain          <= signed'(cfg_data[16:0]);
                REG_WET:        cfg_reg.wet_gain          <= signed'(cfg_data[16:0]);
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    sfdl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .status    (status),
        .cmd       (cmd),
        .state     (state)
    );

    sfdl_datapath #(
        .DELAY_FRAMES (DELAY_FRAMES),
        .CHANNELS     (CHANNELS),
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg       (cfg_reg),
        .src_word  (src_word),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_word  (dst_word)
    );

    // No input taken while the store is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state == ST_CLEAR) |-> !src_ready)
        else $error("input accepted during clear pass");

    // An accepted word makes the block busy next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (src_valid && src_ready) |=> (!src_ready && state == ST_ROM_A))
        else $error("block not busy after accepting a word");

    // A new output word only comes from the finish step
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dst_valid) |-> ($past(state) == ST_FINISH))
        else $error("output word raised outside finish step");

    // Finish never overwrites a pending output word
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_FINISH) |-> (!dst_valid || dst_ready))
        else $error("output word overwritten while stalled");

endmodule

### design/sfdl_ctrl.sv
// Controller state machine for the flanger: sequences the clear pass and the
// per-frame steps of the datapath. Depends on sfdl_pkg.
module sfdl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_ready,
    input  sfdl_pkg::status_t status,
    output sfdl_pkg::cmd_t    cmd,
    output sfdl_pkg::state_t  state
);
    import sfdl_pkg::*;

    state_t state_reg;
    state_t state_next;

    assign state     = state_reg;
    assign src_ready = (state_reg == ST_IDLE);

    // Next state and command
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (status.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (src_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_ROM_A;
                end
            end
            ST_ROM_A:
            begin
                cmd.op     = OP_ROM_A;
                state_next = ST_ROM_B;
            end
            ST_ROM_B:
            begin
                cmd.op     = OP_ROM_B;
                state_next = ST_LFO;
            end
            ST_LFO:
            begin
                cmd.op     = OP_LFO;
                state_next = ST_DELAY;
            end
            ST_DELAY:
            begin
                cmd.op     = OP_DELAY;
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                cmd.op     = OP_ADDR;
                state_next = ST_WR_IN;
            end
            ST_WR_IN:
            begin
                cmd.op     = OP_WR_IN;
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                cmd.op     = OP_RD1;
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                cmd.op     = OP_RD2;
                state_next = ST_INTERP;
            end
            ST_INTERP:
            begin
                cmd.op     = OP_INTERP;
                state_next = ST_STORE;
            end
            ST_STORE:
            begin
                cmd.op     = OP_STORE;
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                cmd.op     = OP_MIX;
                state_next = status.last_chan ? ST_FINISH : ST_WR_IN;
            end
            ST_FINISH:
            begin
                // hold until the output register has room
                if (!status.out_busy)
                begin
                    cmd.op     = OP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

### design/sfdl_datapath.sv
// Datapath for the flanger: LFO sine table, delay computation, delay store,
// interpolation, feedback and mix, plus the output register. Depends on sfdl_pkg.
module sfdl_datapath #(
    parameter int DELAY_FRAMES = sfdl_pkg::DELAY_FRAMES_DEF,
    parameter int CHANNELS     = sfdl_pkg::CHANNELS_DEF,
    parameter int SINE_ENTRIES = sfdl_pkg::SINE_ENTRIES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sfdl_pkg::cmd_t      cmd,
    output sfdl_pkg::status_t   status,
    input  sfdl_pkg::cfg_t      cfg,
    input  sfdl_pkg::in_word_t  src_word,
    output logic                dst_valid,
    input  logic                dst_ready,
    output sfdl_pkg::out_word_t dst_word
);
    import sfdl_pkg::*;

    localparam int FW     = $clog2(DELAY_FRAMES);
    localparam int DEPTH  = DELAY_FRAMES * CHANNELS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SIW    = $clog2(SINE_ENTRIES);
    localparam int POS_W  = 32 + $clog2(SINE_ENTRIES + 1);
    localparam logic [28:0] MAXQ8 = 29'(DELAY_FRAMES * 256 - 1);

    // Sine table built at elaboration
    logic signed [15:0] sine_rom [SINE_ENTRIES];
    for (genvar gi = 0; gi < SINE_ENTRIES; gi++)
    begin : g_sine
        localparam longint U = (longint'(gi) <<< 32) / SINE_ENTRIES;
        localparam logic signed [15:0] ENTRY = sine_of_phase(U);
        assign sine_rom[gi] = ENTRY;
    end

    // Delay store
    logic signed [15:0] store_mem [DEPTH];

    logic [ADDR_W-1:0]  clr_cnt_reg;
    logic [31:0]        phase_reg;
    logic [FW-1:0]      wp_reg;
    in_word_t           in_reg;
    logic [POS_W-1:0]   pos_reg;
    logic signed [15:0] rom_q_reg;
    logic signed [15:0] a_reg;
    logic signed [16:0] lfo_reg;
    logic [24:0]        dq_reg;
    logic [FW-1:0]      rf1_reg;
    logic [FW-1:0]      rf2_reg;
    logic [7:0]         f_reg;
    logic               chan_reg;
    logic signed [15:0] mem_q_reg;
    logic signed [15:0] s1_reg;
    logic signed [15:0] d_reg;
    logic signed [32:0] dryp_reg;
    logic signed [15:0] res_l_reg;
    logic signed [15:0] res_r_reg;
    logic               out_valid_reg;
    out_word_t          out_reg;

    // Table index and neighbor from the scaled phase
    logic [SIW-1:0] idx;
    logic [SIW-1:0] nxt;
    logic [15:0]    frac;
    assign idx  = pos_reg[32 +: SIW];
    assign nxt  = (idx == SIW'(SINE_ENTRIES - 1)) ? '0 : idx + 1'b1;
    assign frac = pos_reg[31:16];

    // LFO interpolation
    logic signed [16:0] lfo_diff;
    logic signed [33:0] lfo_prod;
    logic signed [17:0] lfo_sum;
    assign lfo_diff = 17'(rom_q_reg) - 17'(a_reg);
    assign lfo_prod = 34'(lfo_diff) * 34'(signed'({1'b0, frac}));
    assign lfo_sum  = 18'(a_reg) + 18'(lfo_prod >>> 16);

    // Delay in Q8 frames
    logic [16:0] lfo_off;
    logic [39:0] depth_prod;
    assign lfo_off    = 17'(lfo_reg + 17'sd32768);
    assign depth_prod = cfg.depth_frames * lfo_off[15:0];

    // Clamp and read positions
    logic [28:0]   dq_cl;
    logic [FW-1:0] whole;
    logic [FW:0]   rf1_wide;
    assign dq_cl    = ({4'b0, dq_reg} > MAXQ8) ? MAXQ8 : {4'b0, dq_reg};
    assign whole    = FW'(dq_cl >> 8);
    assign rf1_wide = (wp_reg >= whole) ? ({1'b0, wp_reg} - {1'b0, whole})
                    : ({1'b0, wp_reg} + (FW+1)'(DELAY_FRAMES) - {1'b0, whole});

    // Current channel sample
    logic signed [15:0] x;
    assign x = chan_reg ? in_reg.in_right : in_reg.in_left;

    // Linear interpolation between neighbors
    logic signed [9:0]  w1;
    logic signed [25:0] ip1;
    logic signed [25:0] ip2;
    logic signed [26:0] ip_sum;
    assign w1     = signed'(10'd256 - {2'b0, f_reg});
    assign ip1    = 26'(w1) * 26'(s1_reg);
    assign ip2    = 26'(signed'({2'b0, f_reg})) * 26'(mem_q_reg);
    assign ip_sum = 27'(ip1) + 27'(ip2) + 27'sd128;

    // Feedback into the store
    logic signed [32:0] fb_prod;
    logic signed [35:0] fb_sum;
    assign fb_prod = 33'(d_reg) * 33'(cfg.feedback_gain);
    assign fb_sum  = 36'(x) + 36'((36'(fb_prod) + 36'sd16384) >>> 15);

    // Wet/dry mix
    logic signed [32:0] wet_prod;
    logic signed [35:0] mix_sum;
    assign wet_prod = 33'(d_reg) * 33'(cfg.wet_gain);
    assign mix_sum  = (36'(dryp_reg) + 36'(wet_prod) + 36'sd16384) >>> 15;

    // Memory address for a frame of the current channel
    function automatic logic [ADDR_W-1:0] slot(logic [FW-1:0] frame, logic ch);
        return ADDR_W'(frame) * ADDR_W'(CHANNELS) + ADDR_W'(ch);
    endfunction

    logic [ADDR_W-1:0]  mem_addr;
    logic               mem_we;
    logic signed [15:0] mem_wd;
    always_comb
    begin
        mem_addr = slot(wp_reg, chan_reg);
        mem_we   = 1'b0;
        mem_wd   = x;
        case (cmd.op)
            OP_CLEAR:
            begin
                mem_addr = clr_cnt_reg;
                mem_we   = 1'b1;
                mem_wd   = '0;
            end
            OP_WR_IN:
            begin
                mem_we = 1'b1;
            end
            OP_STORE:
            begin
                mem_we = 1'b1;
                mem_wd = sat16(fb_sum);
            end
            OP_RD1:
            begin
                mem_addr = slot(rf1_reg, chan_reg);
            end
            OP_RD2:
            begin
                mem_addr = slot(rf2_reg, chan_reg);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Single-port store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_addr] <= mem_wd;
        mem_q_reg <= store_mem[mem_addr];
    end

    // Registered sine table read
    always_ff @(posedge clk)
    begin
        rom_q_reg <= sine_rom[(cmd.op == OP_ROM_B) ? nxt : idx];
    end

    // Payload pipeline registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                in_reg    <= src_word;
                pos_reg   <= POS_W'(phase_reg) * POS_W'(SINE_ENTRIES);
                res_r_reg <= '0;
            end
            OP_ROM_B:
            begin
                a_reg <= rom_q_reg;
            end
            OP_LFO:
            begin
                lfo_reg <= 17'(lfo_sum);
            end
            OP_DELAY:
            begin
                dq_reg <= {1'b0, cfg.base_delay_frames} + 25'(depth_prod >> 16);
            end
            OP_ADDR:
            begin
                rf1_reg <= FW'(rf1_wide);
                f_reg   <= dq_cl[7:0];
            end
            OP_WR_IN:
            begin
                rf2_reg <= (rf1_reg == '0) ? FW'(DELAY_FRAMES - 1) : rf1_reg - 1'b1;
            end
            OP_RD2:
            begin
                s1_reg <= mem_q_reg;
            end
            OP_INTERP:
            begin
                d_reg <= 16'(ip_sum >>> 8);
            end
            OP_STORE:
            begin
                dryp_reg <= 33'(x) * 33'(cfg.dry_gain);
            end
            OP_MIX:
            begin
                if (chan_reg)
                    res_r_reg <= sat16(mix_sum);
                else
                    res_l_reg <= sat16(mix_sum);
            end
            default:
            begin
                d_reg <= d_reg;
            end
        endcase
    end

    // Control state: clear counter, channel, write slot, LFO phase, output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            chan_reg      <= 1'b0;
            wp_reg        <= '0;
            phase_reg     <= LFO_PHASE_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // raise on finish, drop once the word is taken
            if (cmd.op == OP_FINISH)
                out_valid_reg <= 1'b1;
            else if (dst_valid && dst_ready)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                OP_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
                OP_ADDR:
                begin
                    chan_reg <= 1'b0;
                end
                OP_MIX:
                begin
                    if (!status.last_chan)
                        chan_reg <= 1'b1;
                end
                OP_FINISH:
                begin
                    wp_reg        <= (wp_reg == FW'(DELAY_FRAMES - 1)) ? '0 : wp_reg + 1'b1;
                    phase_reg     <= phase_reg +
                        ((cfg.phase_increment == '0) ? 32'd1 : cfg.phase_increment);
                end
                default:
                begin
                    chan_reg <= chan_reg;
                end
            endcase
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_FINISH)
        begin
            out_reg.out_left  <= res_l_reg;
            out_reg.out_right <= res_r_reg;
        end
    end

    assign dst_valid         = out_valid_reg;
    assign dst_word          = out_reg;
    assign status.clear_last = (clr_cnt_reg == ADDR_W'(DEPTH - 1));
    assign status.last_chan  = (32'(chan_reg) == 32'(CHANNELS - 1));
    assign status.out_busy   = out_valid_reg && !dst_ready;

endmodule
